### hdl/sha2l_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha2l_pkg;

    localparam int WORD_W = 32;
    localparam int LEN_W  = 61;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [4:0]  LEN_HI_SLOT = 5'd14;

    typedef logic [31:0] word_t;

    typedef word_t hash_t [8];

    function automatic word_t rk_at(input logic [5:0] i);
        word_t r;
        case (i)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic word_t iv_at(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 32'h6a09e667; 3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372; 3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f; 3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab; default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

### hdl/sha2l_round.sv
`timescale 1ns / 1ps
`default_nettype none

// One SHA-256 round plus message schedule step; the 16-word window shifts.
module sha2l_round
(
    input  wire sha2l_pkg::word_t v_in [8],
    input  wire sha2l_pkg::word_t w_in [16],
    input  wire logic [5:0]       round,
    output sha2l_pkg::word_t      v_out [8],
    output sha2l_pkg::word_t      w_out [16]
);

    sha2l_pkg::word_t e1, ch, t1, a0, mj, s0, s1;

    always_comb
    begin
        e1 = sha2l_pkg::rotr(v_in[4], 6) ^ sha2l_pkg::rotr(v_in[4], 11)
           ^ sha2l_pkg::rotr(v_in[4], 25);
        ch = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
        t1 = v_in[7] + e1 + ch + sha2l_pkg::rk_at(round) + w_in[0];
        a0 = sha2l_pkg::rotr(v_in[0], 2) ^ sha2l_pkg::rotr(v_in[0], 13)
           ^ sha2l_pkg::rotr(v_in[0], 22);
        mj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
        v_out[7] = v_in[6];
        v_out[6] = v_in[5];
        v_out[5] = v_in[4];
        v_out[4] = v_in[3] + t1;
        v_out[3] = v_in[2];
        v_out[2] = v_in[1];
        v_out[1] = v_in[0];
        v_out[0] = t1 + a0 + mj;
        s0 = sha2l_pkg::rotr(w_in[1], 7) ^ sha2l_pkg::rotr(w_in[1], 18) ^ (w_in[1] >> 3);
        s1 = sha2l_pkg::rotr(w_in[14], 17) ^ sha2l_pkg::rotr(w_in[14], 19)
           ^ (w_in[14] >> 10);
        for (int i = 0; i < 15; i++)
        begin
            w_out[i] = w_in[i + 1];
        end
        w_out[15] = w_in[0] + s0 + w_in[9] + s1;
    end

endmodule

`default_nettype wire

### hdl/sha256_two_lane_hasher.sv
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 engine with LANE_COUNT independent message contexts.
// Input channel (valid/ready): one big-endian message word per beat with its
// lane, byte_count and last mark. Output channel (valid/ready): eight digest
// beats per finished message, H0 first, digest_last on the eighth.
// Each beat is written into the lane's block buffer. The beat
// that completes a 16-word block starts compression: the block is loaded
// into the schedule window, its 64 rounds run through the single shared
// round unit, and the result is added into the chaining state.
// A last beat adds padding words one per cycle (up to 18 more buffer
// writes) and one or two compressions, then the digest is shown.
// in_ready is low while a block compresses, while padding and while
// digest beats wait, so no new word is taken while a block is in work;
// a stalled receiver holds the engine. Reset returns every lane to the
// initial hash values and empty length.
module sha256_two_lane_hasher #(
    parameter int LANE_COUNT = 2
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [0:0]  lane,
    input  wire  [31:0] data_word,
    input  wire  [2:0]  byte_count,
    input  wire         last,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [0:0]  out_lane,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    localparam int LW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_EMIT
    } state_t;

    state_t            state_reg;
    logic [LW-1:0]     cur_reg;
    logic              fin_reg;
    logic [4:0]        pad_reg;
    logic [5:0]        cnt_reg;
    logic [2:0]        idx_reg;
    logic [3:0]        fill_reg [LANE_COUNT];
    logic [60:0]       len_reg [LANE_COUNT];
    logic [255:0]      hs_reg [LANE_COUNT];
    sha2l_pkg::word_t  v_reg [8];
    sha2l_pkg::word_t  w_reg [16];
    sha2l_pkg::word_t  v_nx [8];
    sha2l_pkg::word_t  w_nx [16];
    sha2l_pkg::word_t  mem [LANE_COUNT * 16];
    sha2l_pkg::word_t  rd_reg;
    logic              rd_ok_reg;

    sha2l_round u_round (
        .v_in(v_reg), .w_in(w_reg), .round(cnt_reg), .v_out(v_nx), .w_out(w_nx)
    );

    logic        lane_ok;
    logic [LW-1:0] in_l;
    logic        acc;
    sha2l_pkg::word_t masked;
    logic [2:0]  cnt_eff;
    logic [60:0] len_add;
    logic [63:0] bits;
    sha2l_pkg::word_t pad_w;

    assign in_l    = LW'(lane);
    assign lane_ok = ({31'd0, lane} < LANE_COUNT);
    assign in_ready = (state_reg == S_IDLE);
    assign acc     = in_valid && in_ready;
    assign out_valid = (state_reg == S_EMIT);
    assign out_lane  = 1'(cur_reg);
    assign word_index = idx_reg;
    assign digest_last = (idx_reg == 3'd7);
    assign digest_word = hs_reg[cur_reg][255 - 32 * idx_reg -: 32];

    always_comb
    begin
        cnt_eff = (!last || byte_count > 3'd4) ? 3'd4 : byte_count;
        len_add = len_reg[in_l] + 61'(cnt_eff);
        case (cnt_eff)
            3'd0: masked = sha2l_pkg::PAD_WORD;
            3'd1: masked = {data_word[31:24], sha2l_pkg::PAD_BYTE, 16'd0};
            3'd2: masked = {data_word[31:16], sha2l_pkg::PAD_BYTE, 8'd0};
            3'd3: masked = {data_word[31:8], sha2l_pkg::PAD_BYTE};
            default: masked = data_word;
        endcase
        bits = {len_reg[cur_reg], 3'b000};
        if (pad_reg == 5'd16)
            pad_w = sha2l_pkg::PAD_WORD;
        else if (fin_reg && fill_reg[cur_reg] == sha2l_pkg::LEN_HI_SLOT[3:0])
            pad_w = bits[63:32];
        else if (fin_reg && fill_reg[cur_reg] == 4'd15)
            pad_w = bits[31:0];
        else
            pad_w = '0;
    end

    always_ff @(posedge clk)
    begin
        if (acc && lane_ok)
            mem[{in_l, fill_reg[in_l]}] <= masked;
        else if (state_reg == S_PAD)
            mem[{cur_reg, fill_reg[cur_reg]}] <= pad_w;
        rd_reg <= mem[{cur_reg, cnt_reg[3:0]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg <= '0;
            fin_reg <= 1'b0;
            pad_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
            rd_ok_reg <= 1'b0;
            for (int l = 0; l < LANE_COUNT; l++)
            begin
                fill_reg[l] <= '0;
                len_reg[l] <= '0;
                for (int k = 0; k < 8; k++)
                    hs_reg[l][255 - 32 * k -: 32] <= sha2l_pkg::iv_at(3'(k));
            end
        end
        else
        begin
            rd_ok_reg <= (state_reg == S_LOAD);
            case (state_reg)
                S_IDLE:
                begin
                    if (acc && lane_ok)
                    begin
                        cur_reg <= in_l;
                        len_reg[in_l] <= len_add;
                        fill_reg[in_l] <= fill_reg[in_l] + 4'd1;
                        // pad 16 = still owe 0x80 word
                        pad_reg <= (last && cnt_eff == 3'd4) ? 5'd16 : 5'd0;
                        if (last && cnt_eff == 3'd4)
                            fin_reg <= (fill_reg[in_l] < 4'd13);
                        else
                            fin_reg <= last && (fill_reg[in_l] < 4'd14);
                        if (last)
                            state_reg <= (fill_reg[in_l] == 4'd15) ? S_LOAD : S_PAD;
                        else if (fill_reg[in_l] == 4'd15)
                            state_reg <= S_LOAD;
                        cnt_reg <= '0;
                        idx_reg <= {2'b00, last};
                    end
                end
                S_PAD:
                begin
                    pad_reg <= '0;
                    fill_reg[cur_reg] <= fill_reg[cur_reg] + 4'd1;
                    if (pad_reg == 5'd16)
                        fin_reg <= (fill_reg[cur_reg] < 4'd14);
                    if (fill_reg[cur_reg] == 4'd15)
                    begin
                        state_reg <= S_LOAD;
                        cnt_reg <= '0;
                    end
                end
                S_LOAD:
                begin
                    // read data comes through rd_reg; the window shifts in one word per valid read
                    if (rd_ok_reg)
                    begin
                        for (int i = 0; i < 15; i++)
                            w_reg[i] <= w_reg[i + 1];
                        w_reg[15] <= rd_reg;
                    end
                    if (cnt_reg == 6'd16)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_ROUND;
                        for (int k = 0; k < 8; k++)
                            v_reg[k] <= hs_reg[cur_reg][255 - 32 * k -: 32];
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_ROUND:
                begin
                    v_reg <= v_nx;
                    w_reg <= w_nx;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int k = 0; k < 8; k++)
                        hs_reg[cur_reg][255 - 32 * k -: 32]
                            <= hs_reg[cur_reg][255 - 32 * k -: 32] + v_reg[k];
                    cnt_reg <= '0;
                    if (idx_reg[0] && fin_reg)
                    begin
                        state_reg <= S_EMIT;
                        idx_reg <= '0;
                    end
                    else if (idx_reg[0])
                    begin
                        state_reg <= S_PAD;
                        fin_reg <= (pad_reg != 5'd16);
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            state_reg <= S_IDLE;
                            fill_reg[cur_reg] <= '0;
                            len_reg[cur_reg] <= '0;
                            for (int k = 0; k < 8; k++)
                                hs_reg[cur_reg][255 - 32 * k -: 32]
                                    <= sha2l_pkg::iv_at(3'(k));
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/sha2l_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sha2l_assert
(
    input wire        clk,
    input wire        rst_n,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [2:0]  word_index,
    input wire        digest_last,
    input wire [0:0]  out_lane
);

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input open during digest");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digest_last == (word_index == 3'd7))) else $error("last flag");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !digest_last |=> out_valid
        && word_index == $past(word_index) + 3'd1) else $error("index step");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_lane))
        else $error("output dropped");

endmodule

bind sha256_two_lane_hasher sha2l_assert u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .word_index(word_index),
    .digest_last(digest_last), .out_lane(out_lane)
);

`default_nettype wire
